[rtl/bcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared widths, request codes, controller command codes and the
// command/status structs of the block cache directory.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int FUNC_W = 2;
    localparam int BLK_W  = 32;
    localparam int SLOT_W = 6;
    localparam int CAP_W  = 7;
    localparam int OP_W   = 4;

    // request kinds
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SYNC  = 2'd3;

    // datapath commands
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
    localparam logic [OP_W-1:0] OP_LK_RD    = 4'd2;
    localparam logic [OP_W-1:0] OP_LK_CMP   = 4'd3;
    localparam logic [OP_W-1:0] OP_HIT      = 4'd4;
    localparam logic [OP_W-1:0] OP_FREE     = 4'd5;
    localparam logic [OP_W-1:0] OP_CLK_SKIP = 4'd6;
    localparam logic [OP_W-1:0] OP_VICT     = 4'd7;
    localparam logic [OP_W-1:0] OP_WB_TAG   = 4'd8;
    localparam logic [OP_W-1:0] OP_INSTALL  = 4'd9;
    localparam logic [OP_W-1:0] OP_SY_RD    = 4'd10;
    localparam logic [OP_W-1:0] OP_SY_EMIT  = 4'd11;
    localparam logic [OP_W-1:0] OP_SY_NONE  = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              out_free;
        logic              match;
        logic              idx_last;
        logic              has_free;
        logic              cnt_ge_cap;
        logic              cnt_gt_cap;
        logic              clk_occ;
        logic              clk_acc;
        logic              vict_dirty;
        logic              wb_pend;
        logic              sync_any;
        logic              emitted;
    } t_stat;

endpackage
`default_nettype wire

[rtl/bcd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcd_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output      logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/bcd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_ctrl
// Request sequencer: lookup scan, hit/flush reply, free-slot fill,
// clock sweep with eviction, and sync over dirty slots.
// ----------------------------------------------------------------------------
module bcd_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [bcd_pkg::FUNC_W-1:0] i_in_func,
    input  wire bcd_pkg::t_stat             i_stat,
    output      bcd_pkg::t_cmd              o_cmd,
    output      logic                       o_in_stall
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LK_RD   = 4'd1;
    localparam logic [3:0] S_LK_CMP  = 4'd2;
    localparam logic [3:0] S_HIT     = 4'd3;
    localparam logic [3:0] S_MISS    = 4'd4;
    localparam logic [3:0] S_CLK     = 4'd5;
    localparam logic [3:0] S_WB_TAG  = 4'd6;
    localparam logic [3:0] S_INSTALL = 4'd7;
    localparam logic [3:0] S_SY_FIND = 4'd8;
    localparam logic [3:0] S_SY_EMIT = 4'd9;

    logic [3:0] r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    // next state and command
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = bcd_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = bcd_pkg::OP_ACCEPT;
                    n_state  = (i_in_func == bcd_pkg::FUNC_SYNC) ? S_SY_FIND : S_LK_RD;
                end
            end
            S_LK_RD: begin
                o_cmd.op = bcd_pkg::OP_LK_RD;
                n_state  = S_LK_CMP;
            end
            S_LK_CMP: begin
                o_cmd.op = bcd_pkg::OP_LK_CMP;
                if (i_stat.match || (i_stat.idx_last && i_stat.func == bcd_pkg::FUNC_FLUSH)) begin
                    n_state = S_HIT;
                end else if (i_stat.idx_last) begin
                    n_state = S_MISS;
                end else begin
                    n_state = S_LK_RD;
                end
            end
            S_HIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = bcd_pkg::OP_HIT;
                    n_state  = S_IDLE;
                end
            end
            S_MISS: begin
                if (i_stat.has_free) begin
                    o_cmd.op = bcd_pkg::OP_FREE;
                    n_state  = S_INSTALL;
                end else begin
                    n_state  = S_CLK;
                end
            end
            S_CLK: begin
                if (i_stat.clk_occ && !i_stat.clk_acc) begin
                    // victim; a pending writeback goes out first
                    if (!i_stat.wb_pend || i_stat.out_free) begin
                        o_cmd.op = bcd_pkg::OP_VICT;
                        if (i_stat.vict_dirty) begin
                            n_state = S_WB_TAG;
                        end else if (i_stat.cnt_gt_cap) begin
                            n_state = S_CLK;
                        end else begin
                            n_state = S_INSTALL;
                        end
                    end
                end else begin
                    o_cmd.op = bcd_pkg::OP_CLK_SKIP;
                end
            end
            S_WB_TAG: begin
                o_cmd.op = bcd_pkg::OP_WB_TAG;
                n_state  = i_stat.cnt_ge_cap ? S_CLK : S_INSTALL;
            end
            S_INSTALL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = bcd_pkg::OP_INSTALL;
                    n_state  = S_IDLE;
                end
            end
            S_SY_FIND: begin
                if (i_stat.sync_any) begin
                    o_cmd.op = bcd_pkg::OP_SY_RD;
                    n_state  = S_SY_EMIT;
                end else if (i_stat.emitted) begin
                    n_state  = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.op = bcd_pkg::OP_SY_NONE;
                    n_state  = S_IDLE;
                end
            end
            S_SY_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = bcd_pkg::OP_SY_EMIT;
                    n_state  = S_SY_FIND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[rtl/bcd_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_dpath
// Directory datapath: tag RAM, slot mark vectors, clock hand, occupancy
// count, capacity register and the result register.
// ----------------------------------------------------------------------------
module bcd_dpath #(
    parameter int SLOTS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bcd_pkg::t_cmd              i_cmd,
    output      bcd_pkg::t_stat             o_stat,
    input  wire logic [bcd_pkg::FUNC_W-1:0] i_in_func,
    input  wire logic [bcd_pkg::BLK_W-1:0]  i_in_block_index,
    input  wire logic                       i_cfg_we,
    input  wire logic [bcd_pkg::CAP_W-1:0]  i_cfg_data,
    input  wire logic                       i_out_stall,
    output      logic                       o_out_valid,
    output      logic                       o_out_hit,
    output      logic [bcd_pkg::SLOT_W-1:0] o_out_slot,
    output      logic                       o_out_fill_needed,
    output      logic                       o_out_writeback_valid,
    output      logic [bcd_pkg::BLK_W-1:0]  o_out_writeback_block,
    output      logic [bcd_pkg::SLOT_W-1:0] o_out_writeback_slot,
    output      logic                       o_out_last
);

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [bcd_pkg::CAP_W-1:0] SLOTS_C = bcd_pkg::CAP_W'(SLOTS);

    // lowest set bit of a slot vector
    function automatic logic [SW-1:0] f_lowest(input logic [SLOTS-1:0] v);
        logic [SW-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) r = SW'(i);
        end
        return r;
    endfunction

    // control registers
    logic [SLOTS-1:0]            r_occ, n_occ, r_dirty, n_dirty, r_acc, n_acc;
    logic [SW-1:0]               r_hand, n_hand;
    logic [bcd_pkg::CAP_W-1:0]   r_count, n_count, r_cap, n_cap;
    logic                        r_found, n_found, r_emitted, n_emitted;
    logic                        r_wb_pend, n_wb_pend, r_out_valid, n_out_valid;
    // payload registers
    logic [bcd_pkg::FUNC_W-1:0]  r_func, n_func;
    logic [bcd_pkg::BLK_W-1:0]   r_blk, n_blk, r_wb_blk, n_wb_blk;
    logic [SW-1:0]               r_idx, n_idx, r_target, n_target, r_wb_slot, n_wb_slot;
    logic                        r_hit, n_hit, r_fill, n_fill, r_wbv, n_wbv, r_last, n_last;
    logic [bcd_pkg::SLOT_W-1:0]  r_slot, n_slot, r_wbs, n_wbs;
    logic [bcd_pkg::BLK_W-1:0]   r_wbb, n_wbb;

    // RAM port
    logic                        w_we, w_re;
    logic [SW-1:0]               w_waddr, w_raddr;
    logic [bcd_pkg::BLK_W-1:0]   w_rdata;

    logic [bcd_pkg::CAP_W-1:0]   w_cap;
    logic [SLOTS-1:0]            w_sync_vec;
    logic [SW-1:0]               w_hand_next, w_sy_slot;
    logic                        w_out_free, w_emit;

    bcd_ram #(.W(bcd_pkg::BLK_W), .D(SLOTS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_blk),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // effective capacity, clamped to 1..SLOTS
    always_comb begin
        if (r_cap == '0)          w_cap = bcd_pkg::CAP_W'(1);
        else if (r_cap > SLOTS_C) w_cap = SLOTS_C;
        else                      w_cap = r_cap;
    end

    assign w_sync_vec  = r_occ & r_dirty;
    assign w_sy_slot   = f_lowest(w_sync_vec);
    assign w_hand_next = (r_hand == LAST_SLOT) ? '0 : r_hand + SW'(1);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // status to the controller
    always_comb begin
        o_stat.func       = r_func;
        o_stat.out_free   = w_out_free;
        o_stat.match      = r_occ[r_idx] && (w_rdata == r_blk);
        o_stat.idx_last   = (r_idx == LAST_SLOT);
        o_stat.has_free   = (r_count < w_cap);
        o_stat.cnt_ge_cap = (r_count >= w_cap);
        o_stat.cnt_gt_cap = (r_count > w_cap);
        o_stat.clk_occ    = r_occ[r_hand];
        o_stat.clk_acc    = r_acc[r_hand];
        o_stat.vict_dirty = r_dirty[r_hand];
        o_stat.wb_pend    = r_wb_pend;
        o_stat.sync_any   = |w_sync_vec;
        o_stat.emitted    = r_emitted;
    end

    // command decode
    always_comb begin
        n_occ = r_occ;  n_dirty = r_dirty;  n_acc = r_acc;
        n_hand = r_hand;  n_count = r_count;
        n_cap = i_cfg_we ? i_cfg_data : r_cap;
        n_found = r_found;  n_emitted = r_emitted;  n_wb_pend = r_wb_pend;
        n_func = r_func;  n_blk = r_blk;  n_wb_blk = r_wb_blk;
        n_idx = r_idx;  n_target = r_target;  n_wb_slot = r_wb_slot;
        n_hit = r_hit;  n_slot = r_slot;  n_fill = r_fill;  n_wbv = r_wbv;
        n_wbb = r_wbb;  n_wbs = r_wbs;  n_last = r_last;
        w_we = 1'b0;  w_waddr = r_target;
        w_re = 1'b0;  w_raddr = r_idx;
        w_emit = 1'b0;
        case (i_cmd.op)
            bcd_pkg::OP_ACCEPT: begin
                n_func = i_in_func;  n_blk = i_in_block_index;
                n_idx = '0;  n_found = 1'b0;  n_emitted = 1'b0;  n_wb_pend = 1'b0;
            end
            bcd_pkg::OP_LK_RD: begin
                w_re = 1'b1;
            end
            bcd_pkg::OP_LK_CMP: begin
                n_found = o_stat.match;
                if (!o_stat.match && r_idx != LAST_SLOT) n_idx = r_idx + SW'(1);
            end
            bcd_pkg::OP_HIT: begin
                w_emit = 1'b1;
                n_hit = r_found;  n_slot = r_found ? bcd_pkg::SLOT_W'(r_idx) : '0;
                n_fill = 1'b0;  n_wbv = 1'b0;  n_wbb = '0;  n_wbs = '0;  n_last = 1'b1;
                if (r_func == bcd_pkg::FUNC_FLUSH) begin
                    if (r_found && r_dirty[r_idx]) begin
                        n_dirty[r_idx] = 1'b0;
                        n_wbv = 1'b1;  n_wbb = r_blk;  n_wbs = bcd_pkg::SLOT_W'(r_idx);
                    end
                end else begin
                    n_acc[r_idx] = 1'b1;
                    if (r_func == bcd_pkg::FUNC_WRITE) n_dirty[r_idx] = 1'b1;
                end
            end
            bcd_pkg::OP_FREE: begin
                n_target = f_lowest(~r_occ);
            end
            bcd_pkg::OP_CLK_SKIP: begin
                // second chance
                if (r_occ[r_hand]) n_acc[r_hand] = 1'b0;
                n_hand = w_hand_next;
            end
            bcd_pkg::OP_VICT: begin
                if (r_wb_pend) begin
                    w_emit = 1'b1;
                    n_hit = 1'b0;  n_slot = '0;  n_fill = 1'b0;  n_wbv = 1'b1;
                    n_wbb = r_wb_blk;  n_wbs = bcd_pkg::SLOT_W'(r_wb_slot);  n_last = 1'b0;
                end
                n_wb_pend = r_dirty[r_hand];
                if (r_dirty[r_hand]) n_wb_slot = r_hand;
                w_re = r_dirty[r_hand];  w_raddr = r_hand;
                n_occ[r_hand] = 1'b0;  n_dirty[r_hand] = 1'b0;  n_acc[r_hand] = 1'b0;
                if (r_count != '0) n_count = r_count - bcd_pkg::CAP_W'(1);
                n_target = r_hand;
                n_hand = w_hand_next;
            end
            bcd_pkg::OP_WB_TAG: begin
                n_wb_blk = w_rdata;
            end
            bcd_pkg::OP_INSTALL: begin
                w_we = 1'b1;
                if (!r_occ[r_target] && r_count < SLOTS_C) n_count = r_count + bcd_pkg::CAP_W'(1);
                n_occ[r_target] = 1'b1;
                n_dirty[r_target] = (r_func == bcd_pkg::FUNC_WRITE);
                n_acc[r_target] = 1'b1;
                w_emit = 1'b1;
                n_hit = 1'b0;  n_slot = bcd_pkg::SLOT_W'(r_target);
                n_fill = (r_func == bcd_pkg::FUNC_READ);
                n_wbv = r_wb_pend;
                n_wbb = r_wb_pend ? r_wb_blk : '0;
                n_wbs = r_wb_pend ? bcd_pkg::SLOT_W'(r_wb_slot) : '0;
                n_last = 1'b1;
                n_wb_pend = 1'b0;
            end
            bcd_pkg::OP_SY_RD: begin
                n_idx = w_sy_slot;
                w_re = 1'b1;  w_raddr = w_sy_slot;
            end
            bcd_pkg::OP_SY_EMIT: begin
                w_emit = 1'b1;
                n_dirty[r_idx] = 1'b0;
                n_emitted = 1'b1;
                n_hit = 1'b0;  n_slot = bcd_pkg::SLOT_W'(r_idx);  n_fill = 1'b0;
                n_wbv = 1'b1;  n_wbb = w_rdata;  n_wbs = bcd_pkg::SLOT_W'(r_idx);
                n_last = ((w_sync_vec & ~(SLOTS'(1) << r_idx)) == '0);
            end
            bcd_pkg::OP_SY_NONE: begin
                w_emit = 1'b1;
                n_hit = 1'b0;  n_slot = '0;  n_fill = 1'b0;  n_wbv = 1'b0;
                n_wbb = '0;  n_wbs = '0;  n_last = 1'b1;
            end
            default: begin
            end
        endcase
        // result register: loaded on emit, drained on transfer
        if (w_emit)            n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
        else                   n_out_valid = r_out_valid;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;  r_dirty <= '0;  r_acc <= '0;
            r_hand <= '0;  r_count <= '0;  r_cap <= bcd_pkg::CAP_W'(64);
            r_found <= 1'b0;  r_emitted <= 1'b0;  r_wb_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;  r_dirty <= n_dirty;  r_acc <= n_acc;
            r_hand <= n_hand;  r_count <= n_count;  r_cap <= n_cap;
            r_found <= n_found;  r_emitted <= n_emitted;  r_wb_pend <= n_wb_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_func <= n_func;  r_blk <= n_blk;  r_wb_blk <= n_wb_blk;
        r_idx <= n_idx;  r_target <= n_target;  r_wb_slot <= n_wb_slot;
        r_hit <= n_hit;  r_slot <= n_slot;  r_fill <= n_fill;  r_wbv <= n_wbv;
        r_wbb <= n_wbb;  r_wbs <= n_wbs;  r_last <= n_last;
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_hit             = r_hit;
    assign o_out_slot            = r_slot;
    assign o_out_fill_needed     = r_fill;
    assign o_out_writeback_valid = r_wbv;
    assign o_out_writeback_block = r_wbb;
    assign o_out_writeback_slot  = r_wbs;
    assign o_out_last            = r_last;

endmodule
`default_nettype wire

[rtl/block_cache_directory_clock.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// block_cache_directory_clock
// Directory of a write-back block cache with CLOCK second-chance replacement.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one request, func and block_index.
// One request is worked on at a time; o_in_stall is high from the transfer
// until the sequencer is back in idle. Output channel (o_out_valid /
// i_out_stall) carries results; o_out_last marks a request's final result.
// The lookup reads and compares the tag RAM slot by slot and stops at a hit.
// A miss fills the lowest free slot while the count is below capacity; else
// the clock hand sweeps and evicts until the count is below it, reading a
// dirty victim's tag in S_WB_TAG. Sync emits a result per dirty slot, or one
// empty result. The input opens again once the final result is loaded. Reset
// (synchronous, active low) empties the directory, parks the hand at slot 0
// and sets capacity to 64; there is no clearing pass. i_cfg_we writes
// capacity_in_use; the user must do so only while the block is idle, as the
// block does not enforce it. While the receiver stalls, the result holds and
// the sequencer waits at its next result.
// ----------------------------------------------------------------------------
module block_cache_directory_clock #(
    parameter int SLOTS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output      logic                       o_in_stall,
    input  wire logic [bcd_pkg::FUNC_W-1:0] i_in_func,
    input  wire logic [bcd_pkg::BLK_W-1:0]  i_in_block_index,
    input  wire logic                       i_cfg_we,
    input  wire logic [bcd_pkg::CAP_W-1:0]  i_cfg_data,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_stall,
    output      logic                       o_out_hit,
    output      logic [bcd_pkg::SLOT_W-1:0] o_out_slot,
    output      logic                       o_out_fill_needed,
    output      logic                       o_out_writeback_valid,
    output      logic [bcd_pkg::BLK_W-1:0]  o_out_writeback_block,
    output      logic [bcd_pkg::SLOT_W-1:0] o_out_writeback_slot,
    output      logic                       o_out_last
);

    bcd_pkg::t_cmd  w_cmd;
    bcd_pkg::t_stat w_stat;

    bcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_func),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    bcd_dpath #(.SLOTS(SLOTS)) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_in_func             (i_in_func),
        .i_in_block_index      (i_in_block_index),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_data            (i_cfg_data),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_out_hit             (o_out_hit),
        .o_out_slot            (o_out_slot),
        .o_out_fill_needed     (o_out_fill_needed),
        .o_out_writeback_valid (o_out_writeback_valid),
        .o_out_writeback_block (o_out_writeback_block),
        .o_out_writeback_slot  (o_out_writeback_slot),
        .o_out_last            (o_out_last)
    );

    // one request at a time: a transfer closes the input until it is done
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a request is in work");

    // a fill is only asked for on a miss
    a_fill_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_fill_needed |-> !o_out_hit && o_out_last)
        else $error("fill_needed on a hit or non-final result");

    // a hit always finishes its request
    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_hit |-> o_out_last)
        else $error("hit result without last");

endmodule
`default_nettype wire

[sim/block_cache_directory_clock_checker.sv]
// ----------------------------------------------------------------------------
// block_cache_directory_clock_checker
// Watches the request, result and capacity ports of the cache directory. It
// keeps its own copy of the directory and the CLOCK hand, predicts the results
// of each request, and compares every result transfer against them in order.
// ----------------------------------------------------------------------------
module block_cache_directory_clock_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic [bcd_pkg::FUNC_W-1:0] i_in_func,
    input  wire logic [bcd_pkg::BLK_W-1:0]  i_in_block_index,
    input  wire logic                       i_cfg_we,
    input  wire logic [bcd_pkg::CAP_W-1:0]  i_cfg_data,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic                       i_out_hit,
    input  wire logic [bcd_pkg::SLOT_W-1:0] i_out_slot,
    input  wire logic                       i_out_fill_needed,
    input  wire logic                       i_out_writeback_valid,
    input  wire logic [bcd_pkg::BLK_W-1:0]  i_out_writeback_block,
    input  wire logic [bcd_pkg::SLOT_W-1:0] i_out_writeback_slot,
    input  wire logic                       i_out_last,
    output int                              o_err_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 64;

    typedef struct packed {
        logic                       hit;
        logic [bcd_pkg::SLOT_W-1:0] slot;
        logic                       fill;
        logic                       wb_valid;
        logic [bcd_pkg::BLK_W-1:0]  wb_block;
        logic [bcd_pkg::SLOT_W-1:0] wb_slot;
        logic                       last;
    } t_dir_result;

    // shadow directory
    logic [bcd_pkg::BLK_W-1:0]  tags      [NSLOT];
    logic                       occ       [NSLOT];
    logic                       dirty     [NSLOT];
    logic                       accessed  [NSLOT];
    logic [bcd_pkg::SLOT_W-1:0] hand;
    int                         occ_count;
    logic [bcd_pkg::CAP_W-1:0]  capacity;

    t_dir_result dir_results_due [$];
    int          err_count = 0;

    assign o_err_count = err_count;
    assign o_pending   = dir_results_due.size();

    function automatic t_dir_result mk(logic h, logic [bcd_pkg::SLOT_W-1:0] s, logic f,
                                       logic wv, logic [bcd_pkg::BLK_W-1:0] wb,
                                       logic [bcd_pkg::SLOT_W-1:0] ws, logic l);
        t_dir_result r;
        r.hit = h; r.slot = s; r.fill = f; r.wb_valid = wv;
        r.wb_block = wb; r.wb_slot = ws; r.last = l;
        return r;
    endfunction

    // append one expected result
    function automatic void add_due(t_dir_result r);
        dir_results_due = {dir_results_due, r};
    endfunction

    // second-chance sweep; -1 when nothing is occupied
    function automatic int clock_sweep();
        logic [bcd_pkg::SLOT_W-1:0] s;
        for (int n = 0; n < 2 * NSLOT + 1; n++) begin
            s = hand;
            hand = hand + 1'b1;
            if (!occ[s]) continue;
            if (accessed[s]) begin
                accessed[s] = 1'b0;
                continue;
            end
            return int'(s);
        end
        return -1;
    endfunction

    function automatic void predict_request(logic [bcd_pkg::FUNC_W-1:0] func,
                                            logic [bcd_pkg::BLK_W-1:0] blk);
        int found;
        int n;
        int cap;
        int target;
        int v;
        logic wb_pend;
        logic [bcd_pkg::BLK_W-1:0] wb_blk;
        logic [bcd_pkg::SLOT_W-1:0] wb_slot;
        found = -1;
        n = 0;
        target = -1;
        wb_pend = 1'b0;
        wb_blk = '0;
        wb_slot = '0;

        // sync: every dirty slot in slot order
        if (func == bcd_pkg::FUNC_SYNC) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (occ[i] && dirty[i]) begin
                    dirty[i] = 1'b0;
                    add_due(mk(1'b0, bcd_pkg::SLOT_W'(i), 1'b0, 1'b1, tags[i],
                               bcd_pkg::SLOT_W'(i), 1'b0));
                    n++;
                end
            end
            if (n == 0) add_due(mk(1'b0, '0, 1'b0, 1'b0, '0, '0, 1'b1));
            else dir_results_due[dir_results_due.size()-1].last = 1'b1;
            return;
        end

        for (int i = 0; i < NSLOT; i++) begin
            if (occ[i] && tags[i] == blk) begin
                found = i;
                break;
            end
        end

        if (func == bcd_pkg::FUNC_FLUSH) begin
            if (found < 0) begin
                add_due(mk(1'b0, '0, 1'b0, 1'b0, '0, '0, 1'b1));
            end else if (dirty[found]) begin
                dirty[found] = 1'b0;
                add_due(mk(1'b1, bcd_pkg::SLOT_W'(found), 1'b0, 1'b1, blk,
                           bcd_pkg::SLOT_W'(found), 1'b1));
            end else begin
                add_due(mk(1'b1, bcd_pkg::SLOT_W'(found), 1'b0, 1'b0, '0, '0, 1'b1));
            end
            return;
        end

        // read or write hit
        if (found >= 0) begin
            accessed[found] = 1'b1;
            if (func == bcd_pkg::FUNC_WRITE) dirty[found] = 1'b1;
            add_due(mk(1'b1, bcd_pkg::SLOT_W'(found), 1'b0, 1'b0, '0, '0, 1'b1));
            return;
        end

        // miss: free slot, else evict until below capacity
        cap = (capacity < 7'd1) ? 1 : (capacity > 7'd64) ? NSLOT : int'(capacity);
        if (occ_count < cap) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!occ[i]) begin
                    target = i;
                    break;
                end
            end
        end
        if (target < 0) begin
            while (occ_count >= cap) begin
                v = clock_sweep();
                if (v < 0) break;
                if (wb_pend) begin
                    add_due(mk(1'b0, '0, 1'b0, 1'b1, wb_blk, wb_slot, 1'b0));
                    wb_pend = 1'b0;
                end
                if (dirty[v]) begin
                    wb_pend = 1'b1;
                    wb_blk = tags[v];
                    wb_slot = bcd_pkg::SLOT_W'(v);
                end
                occ[v] = 1'b0;
                dirty[v] = 1'b0;
                accessed[v] = 1'b0;
                if (occ_count > 0) occ_count--;
                target = v;
            end
        end
        if (target < 0) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!occ[i]) begin
                    target = i;
                    break;
                end
            end
        end
        if (target < 0) target = 0;
        if (!occ[target] && occ_count < NSLOT) occ_count++;
        occ[target] = 1'b1;
        tags[target] = blk;
        dirty[target] = (func == bcd_pkg::FUNC_WRITE);
        accessed[target] = 1'b1;
        add_due(mk(1'b0, bcd_pkg::SLOT_W'(target), func == bcd_pkg::FUNC_READ, wb_pend,
                   wb_pend ? wb_blk : '0, wb_pend ? wb_slot : '0, 1'b1));
    endfunction

    // track requests, capacity writes and result transfers
    always @(posedge i_clk) begin
        t_dir_result got;
        t_dir_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                tags[i] = '0;
                occ[i] = 1'b0;
                dirty[i] = 1'b0;
                accessed[i] = 1'b0;
            end
            hand = '0;
            occ_count = 0;
            capacity = 7'd64;
            dir_results_due.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_data;
            if (i_in_valid && !i_in_stall) predict_request(i_in_func, i_in_block_index);
            if (i_out_valid && !i_out_stall) begin
                got = mk(i_out_hit, i_out_slot, i_out_fill_needed, i_out_writeback_valid,
                         i_out_writeback_block, i_out_writeback_slot, i_out_last);
                if (dir_results_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %p", $realtime, got);
                    err_count++;
                end else begin
                    want = dir_results_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %p actual %p", $realtime, want, got);
                        err_count++;
                    end
                end
            end
        end
    end

endmodule

[sim/block_cache_directory_clock_tb.sv]
// ----------------------------------------------------------------------------
// block_cache_directory_clock_tb
// Drives requests and capacity settings into the cache directory with random
// idle and stall cycles; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module block_cache_directory_clock_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [bcd_pkg::FUNC_W-1:0] i_in_func = bcd_pkg::FUNC_READ;
    logic [bcd_pkg::BLK_W-1:0]  i_in_block_index = '0;
    logic                       i_cfg_we = 1'b0;
    logic [bcd_pkg::CAP_W-1:0]  i_cfg_data = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_out_hit;
    logic [bcd_pkg::SLOT_W-1:0] o_out_slot;
    logic                       o_out_fill_needed;
    logic                       o_out_writeback_valid;
    logic [bcd_pkg::BLK_W-1:0]  o_out_writeback_block;
    logic [bcd_pkg::SLOT_W-1:0] o_out_writeback_slot;
    logic                       o_out_last;
    int                         err_count;
    int                         pending;
    logic                       no_idle = 1'b0;

    always #1 i_clk = ~i_clk;

    block_cache_directory_clock dut (.*);

    block_cache_directory_clock_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in_func,
        .i_in_block_index, .i_cfg_we, .i_cfg_data, .i_out_valid(o_out_valid),
        .i_out_stall, .i_out_hit(o_out_hit), .i_out_slot(o_out_slot),
        .i_out_fill_needed(o_out_fill_needed),
        .i_out_writeback_valid(o_out_writeback_valid),
        .i_out_writeback_block(o_out_writeback_block),
        .i_out_writeback_slot(o_out_writeback_slot), .i_out_last(o_out_last),
        .o_err_count(err_count), .o_pending(pending)
    );

    // random receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 11);
    end

    // one request transfer, with an occasional idle gap before it
    task automatic send_request(logic [bcd_pkg::FUNC_W-1:0] func,
                                logic [bcd_pkg::BLK_W-1:0] blk);
        if (!no_idle && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_func <= func;
        i_in_block_index <= blk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop sending and let every expected result arrive
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_in_stall);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [bcd_pkg::CAP_W-1:0] cap);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [bcd_pkg::CAP_W-1:0] caps [6];
        logic [bcd_pkg::BLK_W-1:0] base;
        logic [bcd_pkg::BLK_W-1:0] blk;
        logic [bcd_pkg::FUNC_W-1:0] func;
        int pool;
        int pick;
        caps = '{7'd5, 7'd64, 7'd1, 7'd96, 7'd16, 7'd33};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty sync, a flush miss, hits, dirty and clean flush
        send_request(bcd_pkg::FUNC_SYNC, 32'h0);
        send_request(bcd_pkg::FUNC_FLUSH, 32'h0);
        send_request(bcd_pkg::FUNC_READ, 32'h0);
        send_request(bcd_pkg::FUNC_READ, 32'h0);
        send_request(bcd_pkg::FUNC_WRITE, 32'hFFFF_FFFF);
        send_request(bcd_pkg::FUNC_WRITE, 32'hFFFF_FFFF);
        send_request(bcd_pkg::FUNC_FLUSH, 32'hFFFF_FFFF);
        send_request(bcd_pkg::FUNC_FLUSH, 32'hFFFF_FFFF);
        send_request(bcd_pkg::FUNC_WRITE, 32'd5);
        send_request(bcd_pkg::FUNC_WRITE, 32'd6);
        send_request(bcd_pkg::FUNC_WRITE, 32'd7);
        send_request(bcd_pkg::FUNC_READ, 32'd8);
        send_request(bcd_pkg::FUNC_WRITE, 32'h0);
        send_request(bcd_pkg::FUNC_SYNC, 32'hA5A5_5A5A);
        send_request(bcd_pkg::FUNC_WRITE, 32'd5);
        send_request(bcd_pkg::FUNC_WRITE, 32'd6);
        send_request(bcd_pkg::FUNC_WRITE, 32'd7);
        // lowered capacity: one miss evicts several dirty blocks
        set_capacity(7'd2);
        send_request(bcd_pkg::FUNC_READ, 32'd9);
        send_request(bcd_pkg::FUNC_WRITE, 32'd10);
        set_capacity(7'd0);
        send_request(bcd_pkg::FUNC_READ, 32'd11);
        send_request(bcd_pkg::FUNC_WRITE, 32'd12);
        set_capacity(7'd127);
        send_request(bcd_pkg::FUNC_READ, 32'd13);
        send_request(bcd_pkg::FUNC_SYNC, 32'h0);

        // random phases, each at its own capacity and block pool
        for (int ph = 0; ph < 6; ph++) begin
            set_capacity(caps[ph]);
            base = $urandom;
            pool = ((caps[ph] > 7'd64) ? 64 : int'(caps[ph])) * 3 / 2 + 2;
            for (int k = 0; k < 70; k++) begin
                no_idle = (ph == 2);
                // the sender holds off once until the directory is quiet
                if (ph == 4 && k == 35) drain();
                pick = $urandom_range(99);
                func = (pick < 36) ? bcd_pkg::FUNC_READ :
                       (pick < 72) ? bcd_pkg::FUNC_WRITE :
                       (pick < 90) ? bcd_pkg::FUNC_FLUSH : bcd_pkg::FUNC_SYNC;
                pick = $urandom_range(99);
                blk = (pick < 85) ? base + $urandom_range(pool - 1) :
                      (pick < 92) ? $urandom :
                      (pick < 96) ? 32'h0 : 32'hFFFF_FFFF;
                send_request(func, blk);
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (300) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
